FILE: hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared constants, controller states and the command and status records
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

   // Fixed widths of the conversion.
   localparam int BinWidth   = 16;
   localparam int NumDigits  = 5;
   localparam int DigitWidth = 4;
   localparam int BcdWidth   = NumDigits * DigitWidth;
   localparam int CharWidth  = 6;
   localparam int IdxWidth   = $clog2(NumDigits);
   localparam int StepWidth  = $clog2(BinWidth);

   localparam logic [CharWidth-1:0]  AsciiZero = 6'd48;
   localparam logic [DigitWidth-1:0] AddThreshold = 4'd5;
   localparam logic [DigitWidth-1:0] AddCorrection = 4'd3;
   localparam logic [StepWidth-1:0]  LastStep = StepWidth'(BinWidth - 1);

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                shift;
      logic [IdxWidth-1:0] digit_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [IdxWidth-1:0] lead_idx;
   } sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/b2da_datapath.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII datapath
// Shift-and-add-3 register pair, leading digit search and ASCII digit select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2da_datapath (
   input  wire                                clock,
   input  wire  b2da_pkg::cmd_type            cmd,
   input  wire  [b2da_pkg::BinWidth-1:0]      value,
   output b2da_pkg::sts_type                  sts,
   output logic [b2da_pkg::CharWidth-1:0]     digit_char
);
   import b2da_pkg::*;

   logic [BinWidth-1:0]   bin_ff;
   logic [BinWidth-1:0]   bin_in;
   logic [BcdWidth-1:0]   bcd_ff;
   logic [BcdWidth-1:0]   bcd_in;
   logic [BcdWidth-1:0]   bcd_adj;
   logic [DigitWidth-1:0] sel_digit;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[i*DigitWidth +: DigitWidth] >= AddThreshold) begin
            bcd_adj[i*DigitWidth +: DigitWidth] =
               bcd_ff[i*DigitWidth +: DigitWidth] + AddCorrection;
         end else begin
            bcd_adj[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth];
         end
      end
   end

   // Next value of the conversion registers.
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (cmd.shift) begin
         bin_in = {bin_ff[BinWidth-2:0], 1'b0};
         bcd_in = {bcd_adj[BcdWidth-2:0], bin_ff[BinWidth-1]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // Position of the most significant nonzero digit of the next register
   // value, so the final shift is included; zero gives the lowest.
   always_comb begin
      sts.lead_idx = '0;
      for (int i = 1; i < NumDigits; i++) begin
         if (bcd_in[i*DigitWidth +: DigitWidth] != '0) begin
            sts.lead_idx = IdxWidth'(i);
         end
      end
   end

   // Select the digit being sent and form its character code.
   always_comb begin
      sel_digit = '0;
      for (int i = 0; i < NumDigits; i++) begin
         if (cmd.digit_sel == IdxWidth'(i)) begin
            sel_digit = bcd_ff[i*DigitWidth +: DigitWidth];
         end
      end
      digit_char = AsciiZero + CharWidth'(sel_digit);
   end

endmodule

`default_nettype wire

FILE: hw/rtl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII controller
// Sequences the load, the sixteen conversion steps and the digit transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2da_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic                 rsp_last_digit,
   input  wire  b2da_pkg::sts_type sts,
   output b2da_pkg::cmd_type    cmd
);
   import b2da_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   logic [StepWidth-1:0] step_ff;
   logic [StepWidth-1:0] step_in;
   logic [IdxWidth-1:0]  idx_ff;
   logic [IdxWidth-1:0]  idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state and command outputs.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_last_digit = 1'b0;
      cmd.load       = 1'b0;
      cmd.shift      = 1'b0;
      cmd.digit_sel  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // The first digit sent is the leading nonzero one, or the lowest digit for a zero value.
            rsp_valid      = 1'b1;
            rsp_last_digit = (idx_ff == '0);
            if (rsp_ready) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Latch the leading digit position as the conversion finishes.
      if (state_ff == ST_CONVERT && step_ff == LastStep) begin
         idx_in = sts.lead_idx;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Converts an unsigned 16-bit value to its decimal digits as ASCII codes,
// most significant first, without leading zeros.
// ----------------------------------------------------------------------------
// After the input transfer come the 16 shift-and-add-3 steps; then the first
// digit is offered, and digits follow at one per cycle while rsp_ready is high.
// Each value passes through the idle state, the conversion and its digits.
// A new value is taken only after the last digit of the previous one.
// Reset is synchronous, active high, and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [15:0] req_value,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [5:0] rsp_digit_char,
   output logic       rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of load, conversion and digit transfers.
   b2da_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_last_digit (rsp_last_digit),
      .sts            (sts),
      .cmd            (cmd)
   );

   // Conversion registers and digit select.
   b2da_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .value      (req_value),
      .sts        (sts),
      .digit_char (rsp_digit_char)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter testbench
// Sends unsigned 16-bit values and checks every digit character that comes
// back, most significant first, against digits computed here by repeated
// division by ten. Directed values cover the digit-count boundaries. Random
// values are spread over all digit counts. Both sides idle in short random
// bursts, and one long receiver hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import b2da_pkg::BinWidth;
   import b2da_pkg::CharWidth;

   localparam int                   Radix      = 10;
   localparam int                   MaxDigits  = 5;
   localparam logic [CharWidth-1:0] CharZero   = 6'd48;
   localparam int                   HoldCycles = 300;
   localparam int                   DrainWait  = 40;

   // One expected digit character.
   typedef struct {
      logic [CharWidth-1:0] digit_char;
      logic                 last_digit;
   } digit_rec_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BinWidth-1:0]  req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CharWidth-1:0] rsp_digit_char;
   logic                 rsp_last_digit;

   digit_rec_type pending_digits[$];
   int            mismatch_count = 0;
   bit            gap_enable = 1'b0;
   bit            stall_enable = 1'b0;
   bit            hold_request = 1'b0;

   binary_to_decimal_ascii_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   always #1 clock = ~clock;

   // Queue the decimal characters of a value, most significant first.
   function automatic void queue_decimal_digits(input logic [BinWidth-1:0] value);
      int unsigned   rest;
      int unsigned   digs[MaxDigits];
      int            count;
      digit_rec_type rec;
      rest  = value;
      count = 0;
      do begin
         digs[count] = rest % Radix;
         rest        = rest / Radix;
         count++;
      end while (rest != 0 && count < MaxDigits);
      for (int k = count - 1; k >= 0; k--) begin
         rec.digit_char = CharZero + CharWidth'(digs[k]);
         rec.last_digit = (k == 0);
         pending_digits.push_back(rec);
      end
   endfunction

   // Offer one value, optionally after a short idle burst, and wait for its transfer.
   task automatic send_value(input logic [BinWidth-1:0] value);
      if (gap_enable && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         req_value <= BinWidth'($urandom);
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      queue_decimal_digits(value);
   endtask

   // Random value over all digit counts, five digits picked twice as often; sometimes any 16-bit value.
   function automatic logic [BinWidth-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: pick_value = BinWidth'($urandom);
         1: pick_value = BinWidth'($urandom_range(0, 9));
         2: pick_value = BinWidth'($urandom_range(10, 99));
         3: pick_value = BinWidth'($urandom_range(100, 999));
         4: pick_value = BinWidth'($urandom_range(1000, 9999));
         default: pick_value = BinWidth'($urandom_range(10000, 65535));
      endcase
   endfunction

   // Receiver: ready with random stall bursts, or one long hold-off on request.
   initial begin : receiver
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else if (stall_enable && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest expected digit.
   always @(posedge clock) begin
      digit_rec_type exp_rec;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit transfer: digit_char %0d last_digit %0b",
                   rsp_digit_char, rsp_last_digit);
            mismatch_count++;
         end else begin
            exp_rec = pending_digits.pop_front();
            if (rsp_digit_char !== exp_rec.digit_char) begin
               $error("digit_char: expected %0d, actual %0d",
                      exp_rec.digit_char, rsp_digit_char);
               mismatch_count++;
            end
            if (rsp_last_digit !== exp_rec.last_digit) begin
               $error("last_digit: expected %0b, actual %0b",
                      exp_rec.last_digit, rsp_last_digit);
               mismatch_count++;
            end
         end
      end
   end

   // Zero, the digit-count boundaries, all-ones and alternating bit patterns.
   task automatic test_directed();
      logic [BinWidth-1:0] values[] = '{
         16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
         16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'd12345,
         16'd10001, 16'd50005, 16'h5555, 16'hAAAA, 16'd7, 16'd60000, 16'd40960
      };
      foreach (values[i]) send_value(values[i]);
   endtask

   // Long receiver hold-off while the sender keeps offering values.
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (8) send_value(pick_value());
   endtask

   // Random values with idle bursts on both sides.
   task automatic test_random(input int count);
      gap_enable   = 1'b1;
      stall_enable = 1'b1;
      repeat (count) send_value(pick_value());
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_streaming(input int count);
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      repeat (count) send_value(pick_value());
   endtask

   initial begin : main
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(300);
      test_streaming(40);

      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
